// File: rtl/mdds_pkg.sv
// shared types, constants and the sine table of the multichannel dds generator
`default_nettype none

package mdds_pkg;

    // field widths fixed by the stream format
    localparam int unsigned STEP_W     = 32;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned CH_FIELD_W = 3;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned NUM_STEPS  = 8;
    localparam int unsigned STEP_IDX_W = 3;
    localparam int unsigned ROM_ADDR_W = 8;
    localparam int unsigned ROM_DEPTH  = 256;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 24;

    // request kinds carried on tuser
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_BYTE = 1'b1;

    // text command words, first character in byte 0
    localparam int unsigned MAX_WORD   = 7;
    localparam int unsigned WORD_IDX_W = 3;
    typedef logic [MAX_WORD-1:0][BYTE_W-1:0] word_t;

    localparam logic [BYTE_W-1:0] NL_CHAR = 8'h0A;
    localparam word_t WORD_START   = {8'h00, 8'h00, "T", "R", "A", "T", "S"};
    localparam word_t WORD_STOP    = {8'h00, 8'h00, 8'h00, "P", "O", "T", "S"};
    localparam word_t WORD_ENABLE  = {8'h00, "E", "L", "B", "A", "N", "E"};
    localparam word_t WORD_DISABLE = {"E", "L", "B", "A", "S", "I", "D"};
    localparam int unsigned LEN_START   = 5;
    localparam int unsigned LEN_STOP    = 4;
    localparam int unsigned LEN_ENABLE  = 6;
    localparam int unsigned LEN_DISABLE = 7;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // controller to datapath: one sample per advance
    typedef struct packed {
        logic                  adv;
        logic [CH_FIELD_W-1:0] ch;
        logic                  last;
    } emit_cmd_t;

    // parser flags seen by the controller
    typedef struct packed {
        logic running;
        logic enabled;
    } run_flags_t;

    // sine table, entry i = floor(32767.5 * (1 + sin(2*pi*i/256))) in q30 arithmetic
    typedef logic [ROM_DEPTH-1:0][SAMPLE_W-1:0] rom_t;

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    // truncating quotient by shift and subtract, evaluated while the table is built
    function automatic logic [63:0] trunc_quotient(input logic [63:0] num,
                                                   input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        int          b;
        rem = '0;
        quo = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sin(pi*k/128) in q30 for k in 0..64, taylor series in horner form
    function automatic logic [63:0] quarter_sine(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] sub;
        int          n;
        if (k >= 64) begin
            s = Q30_ONE;
        end else begin
            x  = (PI_Q30 * 64'(k)) >> 7;
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            for (n = 12; n >= 1; n--) begin
                sub = trunc_quotient((x2 * t) >> 30, 64'((2 * n) * (2 * n + 1)));
                t   = (sub >= Q30_ONE) ? 64'd0 : (Q30_ONE - sub);
            end
            s = (x * t) >> 30;
            if (s > Q30_ONE) begin
                s = Q30_ONE;
            end
        end
        return s;
    endfunction

    // full table from quarter-wave symmetry, evaluated at elaboration
    function automatic rom_t build_sine_rom();
        rom_t        rom;
        int unsigned i;
        int unsigned q;
        int unsigned k;
        logic [63:0] s;
        logic [63:0] v;
        for (i = 0; i < ROM_DEPTH; i++) begin
            q = i & 127;
            k = (q <= 64) ? q : (128 - q);
            s = quarter_sine(k);
            v = (i < 128) ? (Q30_ONE + s) : (Q30_ONE - s);
            rom[i] = SAMPLE_W'((v * 64'd65535) >> 31);
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_sine_rom();

    // exact match of the kept line against a command word
    function automatic logic word_match(input word_t line, input word_t word,
                                        input int unsigned word_len);
        logic        eq;
        int unsigned b;
        eq = 1'b1;
        for (b = 0; b < MAX_WORD; b++) begin
            if (b < word_len && line[b] != word[b]) begin
                eq = 1'b0;
            end
        end
        return eq;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mdds_line_parser.sv
// text line store and command decoder that set the run and enable flags
`default_nettype none

module mdds_line_parser #(
    parameter int unsigned LINE_CHARS = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       byte_we,
    input  wire logic [7:0]                 rx_byte,
    output mdds_pkg::run_flags_t            flags
);
    import mdds_pkg::*;

    localparam int unsigned LEN_W = $clog2(LINE_CHARS);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CHARS - 1);

    // only the first bytes can ever match a command word, later ones are counted only
    word_t              line_reg;
    logic [LEN_W-1:0]   len_reg, len_next;
    run_flags_t         flags_reg, flags_next;

    // command decode on newline, line length count on other bytes
    always_comb begin
        flags_next = flags_reg;
        len_next   = len_reg;
        if (byte_we) begin
            if (rx_byte == NL_CHAR) begin
                len_next = '0;
                if (len_reg == LEN_W'(LEN_START)
                    && word_match(line_reg, WORD_START, LEN_START)) begin
                    flags_next.running = 1'b1;
                end else if (len_reg == LEN_W'(LEN_STOP)
                             && word_match(line_reg, WORD_STOP, LEN_STOP)) begin
                    flags_next.running = 1'b0;
                end else if (len_reg == LEN_W'(LEN_ENABLE)
                             && word_match(line_reg, WORD_ENABLE, LEN_ENABLE)) begin
                    flags_next.enabled = 1'b1;
                end else if (len_reg == LEN_W'(LEN_DISABLE)
                             && word_match(line_reg, WORD_DISABLE, LEN_DISABLE)) begin
                    flags_next.enabled = 1'b0;
                end
            end else if (len_reg < LEN_MAX) begin
                len_next = len_reg + LEN_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
            len_reg   <= '0;
        end else begin
            flags_reg <= flags_next;
            len_reg   <= len_next;
        end
    end

    // byte store, no reset needed
    always_ff @(posedge aclk) begin
        if (byte_we && rx_byte != NL_CHAR && len_reg < LEN_W'(MAX_WORD)) begin
            line_reg[len_reg[WORD_IDX_W-1:0]] <= rx_byte;
        end
    end

    assign flags = flags_reg;

endmodule

`default_nettype wire

// File: rtl/mdds_ctrl.sv
// controller state machine: input handshake and channel sequencing
`default_nettype none

module mdds_ctrl #(
    parameter int unsigned CHANNELS = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic                   s_tuser,
    input  wire mdds_pkg::run_flags_t   flags,
    input  wire logic                   out_free,
    output logic                        byte_we,
    output mdds_pkg::emit_cmd_t         emit
);
    import mdds_pkg::*;

    localparam logic [CH_FIELD_W-1:0] LAST_CH = CH_FIELD_W'(CHANNELS - 1);

    state_t                 state_reg, state_next;
    logic [CH_FIELD_W-1:0]  ch_reg, ch_next;
    logic                   accept;
    logic                   active;

    assign accept = s_tvalid && (state_reg == ST_IDLE);
    assign active = flags.running && flags.enabled;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_tuser == KIND_TICK && active) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free && ch_reg == LAST_CH) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready  = 1'b0;
        byte_we   = 1'b0;
        emit.adv  = 1'b0;
        emit.ch   = ch_reg;
        emit.last = (ch_reg == LAST_CH);
        ch_next   = ch_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                byte_we  = accept && s_tuser == KIND_BYTE;
                ch_next  = '0;
            end
            ST_EMIT: begin
                emit.adv = out_free;
                if (out_free) begin
                    ch_next = ch_reg + CH_FIELD_W'(1);
                end
            end
            default: begin
                ch_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ch_reg    <= '0;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mdds_datapath.sv
// step registers, phase accumulators, sine lookup and output register
`default_nettype none

module mdds_datapath #(
    parameter int unsigned CHANNELS = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [31:0]            cfg_wdata,
    input  wire mdds_pkg::emit_cmd_t    emit,
    output logic                        out_free,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [23:0]                 m_tdata,
    output logic                        m_tlast
);
    import mdds_pkg::*;

    localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [STEP_W-1:0]      step_reg  [NUM_STEPS];
    logic [STEP_W-1:0]      phase_reg [CHANNELS];
    logic [STEP_W-1:0]      phase_next;
    logic [IDX_W-1:0]       idx;
    logic                   valid_reg, valid_next;
    logic [CH_FIELD_W-1:0]  ch_out_reg;
    logic [SAMPLE_W-1:0]    sample_reg;
    logic                   last_reg;

    assign idx        = emit.ch[IDX_W-1:0];
    assign phase_next = phase_reg[idx] + step_reg[emit.ch[STEP_IDX_W-1:0]];
    assign out_free   = !valid_reg || m_tready;

    // step registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STEPS; i++) begin
                step_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            step_reg[cfg_index] <= cfg_wdata;
        end
    end

    // phase accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                phase_reg[i] <= '0;
            end
        end else if (emit.adv) begin
            phase_reg[idx] <= phase_next;
        end
    end

    // output valid
    always_comb begin
        valid_next = valid_reg;
        if (emit.adv) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // output payload from the table
    always_ff @(posedge aclk) begin
        if (emit.adv) begin
            ch_out_reg <= emit.ch;
            sample_reg <= SINE_ROM[phase_next[STEP_W-1 -: ROM_ADDR_W]];
            last_reg   <= emit.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'b0, sample_reg, ch_out_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// File: rtl/multichannel_dds_sine_generator_core.sv
// top level of the multichannel dds sine generator
//
// Input stream s_*: each request is a sample tick (s_tuser 0) or a received
// text byte (s_tuser 1, character in s_tdata). Text lines ending in newline
// are matched against START, STOP, ENABLE and DISABLE to set the run flags.
// Output stream m_*: on a tick with both flags set, one sample per channel
// in channel order, m_tlast on the final channel; other ticks give nothing.
// The user must load step registers through cfg_we/cfg_index/cfg_wdata
// only while idle; the block itself does not enforce it. A byte or
// inactive tick is handled in idle. An active tick steps the channel
// sequencer (one shared adder and sine table) through every channel and
// then returns to idle; the state register moves to emit, then the first sample is loaded into the output register.
// When the receiver stalls, the output register holds and the sequencer
// waits; s_tready stays low until the last channel is handed over.
// Synchronous active-low reset clears phases, steps, flags and line length.
`default_nettype none

module multichannel_dds_sine_generator_core #(
    parameter int unsigned CHANNELS   = 8,
    parameter int unsigned LINE_CHARS = 32
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    // configuration write port
    input  wire logic           cfg_we,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [31:0]    cfg_wdata,
    // input stream
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,   // [7:0] rx_byte
    input  wire logic           s_tuser,   // [0] cmd
    // output stream
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [23:0]         m_tdata,   // [2:0] channel, [18:3] sample, [23:19] zero
    output logic                m_tlast    // last
);
    import mdds_pkg::*;

    run_flags_t flags;
    emit_cmd_t  emit;
    logic       byte_we;
    logic       out_free;

    mdds_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .flags    (flags),
        .out_free (out_free),
        .byte_we  (byte_we),
        .emit     (emit)
    );

    mdds_line_parser #(
        .LINE_CHARS (LINE_CHARS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_we (byte_we),
        .rx_byte (s_tdata),
        .flags   (flags)
    );

    mdds_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .emit      (emit),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// File: bench/tb.sv
// self-checking testbench for the multichannel dds sine generator core
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mdds_pkg::*;

    localparam int NUM_CH        = 8;
    localparam int LINE_LEN      = 32;
    localparam int LINE_KEEP     = LINE_LEN - 1;
    localparam int SETTLE_CYCLES = NUM_CH + 4;
    localparam int STALL_LIMIT   = 2000;
    localparam int LONG_HOLD     = 300;

    localparam longint unsigned ONE_Q30   = 64'd1073741824;
    localparam longint unsigned PI_IN_Q30 = 64'd3373259426;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic [CH_FIELD_W-1:0] channel;
        logic [SAMPLE_W-1:0]   sample;
        logic                  last;
    } dds_sample_t;

    // dut ports, inputs known from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [2:0]            cfg_index = '0;
    logic [STEP_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = KIND_TICK;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    // predictor state
    logic [SAMPLE_W-1:0] sine_table [ROM_DEPTH];
    logic [STEP_W-1:0]   pred_step  [NUM_CH];
    logic [STEP_W-1:0]   pred_phase [NUM_CH];
    logic [STEP_W-1:0]   step_plan  [NUM_CH];
    logic                run_flag = 1'b0;
    logic                out_flag = 1'b0;
    byte_q_t             cmd_line;
    dds_sample_t         expected_samples[$];

    // bookkeeping
    int error_count   = 0;
    int items_sent    = 0;
    int burst_left    = 0;
    bit steady_sender = 1'b0;
    int long_hold_req = 0;
    int idle_cycles   = 0;

    multichannel_dds_sine_generator_core #(
        .CHANNELS   (NUM_CH),
        .LINE_CHARS (LINE_LEN)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // sin(pi*k/128) in q30, truncating horner series, quarter wave only
    function automatic longint unsigned sin_q30(input int unsigned k);
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned acc;
        longint unsigned den;
        longint unsigned term;
        longint unsigned s;
        if (k >= 64) begin
            return ONE_Q30;
        end
        ang    = (PI_IN_Q30 * k) >> 7;
        ang_sq = (ang * ang) >> 30;
        acc    = ONE_Q30;
        for (int n = 12; n >= 1; n--) begin
            den  = 64'(2 * n) * 64'(2 * n + 1);
            term = ((ang_sq * acc) >> 30) / den;
            acc  = (term >= ONE_Q30) ? 64'd0 : (ONE_Q30 - term);
        end
        s = (ang * acc) >> 30;
        return (s > ONE_Q30) ? ONE_Q30 : s;
    endfunction

    // unsigned table entry from quarter-wave symmetry
    function automatic logic [SAMPLE_W-1:0] sine_sample(input int unsigned idx);
        int unsigned     q;
        int unsigned     k;
        longint unsigned s;
        longint unsigned v;
        q = idx & 127;
        k = (q <= 64) ? q : (128 - q);
        s = sin_q30(k);
        v = (idx < 128) ? (ONE_Q30 + s) : (ONE_Q30 - s);
        return SAMPLE_W'((v * 64'd65535) >> 31);
    endfunction

    function automatic bit line_matches(input string word);
        if (cmd_line.size() != word.len()) begin
            return 1'b0;
        end
        for (int i = 0; i < word.len(); i++) begin
            if (cmd_line[i] != word[i]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // advance the predictor by one accepted request
    function automatic void predict_request(input logic kind, input logic [7:0] data);
        dds_sample_t rec;
        if (kind == KIND_BYTE) begin
            if (data == NL_CHAR) begin
                if (line_matches("START")) begin
                    run_flag = 1'b1;
                end else if (line_matches("STOP")) begin
                    run_flag = 1'b0;
                end else if (line_matches("ENABLE")) begin
                    out_flag = 1'b1;
                end else if (line_matches("DISABLE")) begin
                    out_flag = 1'b0;
                end
                cmd_line.delete();
            end else if (cmd_line.size() < LINE_KEEP) begin
                cmd_line.push_back(data);
            end
        end else if (run_flag && out_flag) begin
            for (int c = 0; c < NUM_CH; c++) begin
                pred_phase[c] = pred_phase[c] + pred_step[c];
                rec.channel   = CH_FIELD_W'(c);
                rec.sample    = sine_table[pred_phase[c][31:24]];
                rec.last      = (c == NUM_CH - 1);
                expected_samples.push_back(rec);
            end
        end
    endfunction

    function automatic byte_q_t text_bytes(input string text);
        byte_q_t chars;
        for (int i = 0; i < text.len(); i++) begin
            chars.push_back(text[i]);
        end
        return chars;
    endfunction

    // start and enable come more often so that most ticks are active
    function automatic string command_word();
        case ($urandom_range(0, 7))
            0, 1, 2: return "START";
            3, 4, 5: return "ENABLE";
            6:       return "STOP";
            default: return "DISABLE";
        endcase
    endfunction

    // offer one request, with bursts and random gaps, and wait for acceptance
    task automatic send_request(input logic kind, input logic [7:0] data);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (!steady_sender) begin
                gap = $urandom_range(0, 10);
            end
        end
        burst_left--;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        predict_request(kind, data);
    endtask

    task automatic send_tick();
        send_request(KIND_TICK, 8'($urandom()));
    endtask

    task automatic send_line(input byte_q_t text);
        foreach (text[i]) begin
            send_request(KIND_BYTE, text[i]);
        end
        send_request(KIND_BYTE, NL_CHAR);
    endtask

    // stop offering and wait until every expected sample has come out
    task automatic pause_input();
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // load step_plan into the step registers, only while idle
    task automatic write_steps();
        for (int i = 0; i < NUM_CH; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_wdata <= step_plan[i];
            @(posedge aclk);
            pred_step[i] = step_plan[i];
        end
        cfg_we <= 1'b0;
    endtask

    // mostly tick bursts and command lines, some broken lines and noise
    task automatic run_mixed_traffic(input int n_items);
        int          stop_at;
        int          pick;
        int          len;
        int          pos;
        byte_q_t     text;
        logic [7:0]  b;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                repeat ($urandom_range(1, 6)) send_tick();
            end else if (pick < 72) begin
                send_line(text_bytes(command_word()));
            end else if (pick < 84) begin
                // command word spoiled in one of several ways
                text = text_bytes(command_word());
                case ($urandom_range(0, 5))
                    0: text.push_back(8'h0D);
                    1: text.push_back(8'h00);
                    2: void'(text.pop_back());
                    3: begin
                        pos = $urandom_range(0, text.size() - 1);
                        text[pos] = text[pos] ^ 8'h20;
                    end
                    4: text.push_front(8'h20);
                    default: text.push_back(8'($urandom_range(8'h41, 8'h5A)));
                endcase
                send_line(text);
            end else if (pick < 90) begin
                // line longer than the store, sometimes opening with a command
                text.delete();
                if ($urandom_range(0, 1) == 1) begin
                    text = text_bytes(command_word());
                end
                len  = $urandom_range(LINE_KEEP, LINE_KEEP + 9);
                while (text.size() < len) begin
                    do begin
                        b = 8'($urandom());
                    end while (b == NL_CHAR);
                    text.push_back(b);
                end
                send_line(text);
            end else begin
                send_request(KIND_BYTE, 8'($urandom()));
            end
        end
    endtask

    // ticks right after reset and while not running give nothing
    task automatic test_inactive_ticks();
        send_request(KIND_TICK, 8'h00);
        send_request(KIND_TICK, 8'hFF);
        send_line(text_bytes("ENABLE"));
        send_tick();
    endtask

    // start makes ticks active, stop makes them silent again
    task automatic test_command_words();
        send_line(text_bytes("START"));
        send_tick();
        send_tick();
        send_line(text_bytes("STOP"));
        send_tick();
    endtask

    task automatic test_random_steps();
        pause_input();
        foreach (step_plan[i]) step_plan[i] = $urandom();
        write_steps();
        run_mixed_traffic(110);
    endtask

    task automatic test_extreme_steps();
        pause_input();
        foreach (step_plan[i]) step_plan[i] = 32'hFFFF_FFFF;
        write_steps();
        run_mixed_traffic(80);
    endtask

    // slow phase movement with a sender that never pauses
    task automatic test_slow_steps();
        pause_input();
        foreach (step_plan[i]) step_plan[i] = $urandom() >> $urandom_range(8, 31);
        write_steps();
        steady_sender = 1'b1;
        run_mixed_traffic(80);
        steady_sender = 1'b0;
    endtask

    // receiver holds off long enough for the input to back up
    task automatic test_output_stall();
        pause_input();
        foreach (step_plan[i]) step_plan[i] = (i % 2 == 0) ? 32'h8000_0000 : $urandom();
        step_plan[0] = '0;
        write_steps();
        send_request(KIND_BYTE, NL_CHAR);
        send_line(text_bytes("ENABLE"));
        send_line(text_bytes("START"));
        long_hold_req = LONG_HOLD;
        repeat (8) send_tick();
        run_mixed_traffic(20);
    endtask

    // stimulus sequence
    initial begin
        for (int i = 0; i < ROM_DEPTH; i++) begin
            sine_table[i] = sine_sample(i);
        end
        foreach (pred_phase[i]) begin
            pred_phase[i] = '0;
            pred_step[i]  = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        step_plan = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0100_0000,
                      32'h0000_0001, 32'h4000_0000, 32'h7FFF_FFFF, 32'hC000_0000};
        write_steps();
        test_inactive_ticks();
        test_command_words();
        test_random_steps();
        test_extreme_steps();
        test_slow_steps();
        test_output_stall();
        pause_input();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // receiver ready pattern, changing mode now and then, plus the long hold
    always @(posedge aclk) begin : drive_ready
        int hold_left;
        int mode_left;
        int ready_mode;
        if (long_hold_req > 0) begin
            hold_left     = long_hold_req;
            long_hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 96);
            end
            mode_left--;
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 1);
                2:       m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ((mode_left % 4) != 0);
            endcase
        end
    end

    // compare every accepted sample with the oldest prediction
    always @(posedge aclk) begin : check_samples
        dds_sample_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                $error("unexpected sample: channel %0d sample %0d last %0b",
                       m_tdata[2:0], m_tdata[18:3], m_tlast);
                error_count++;
            end else begin
                want = expected_samples.pop_front();
                if (m_tdata[2:0] != want.channel) begin
                    $error("channel mismatch: expected %0d, got %0d",
                           want.channel, m_tdata[2:0]);
                    error_count++;
                end
                if (m_tdata[18:3] != want.sample) begin
                    $error("sample mismatch: expected %0d, got %0d",
                           want.sample, m_tdata[18:3]);
                    error_count++;
                end
                if (m_tlast != want.last) begin
                    $error("last mismatch: expected %0b, got %0b", want.last, m_tlast);
                    error_count++;
                end
                if (m_tdata[23:19] != '0) begin
                    $error("pad mismatch: expected 0, got %0d", m_tdata[23:19]);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no request and no sample moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $error("nothing moved for %0d cycles, %0d samples still expected",
                   STALL_LIMIT, expected_samples.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

`default_nettype wire
